FILE: sv/mscf_pkg.sv
// Shared types and constants for the memory search candidate filter.
// Register indexes, command and comparison codes, field widths and mask helpers.
// No dependencies.
package mscf_pkg;

	// Fixed field widths
	localparam int unsigned ADDR_W  = 22;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 23;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Configuration register indexes
	localparam logic [1:0] REG_SEARCH_MODE  = 2'd0;
	localparam logic [1:0] REG_ELEMENT_SIZE = 2'd1;
	localparam logic [1:0] REG_COMPARE_OP   = 2'd2;
	localparam logic [1:0] REG_TARGET_VALUE = 2'd3;

	// Search modes
	localparam logic MODE_EXACT       = 1'b0;
	localparam logic MODE_COMPARATIVE = 1'b1;

	// Item commands
	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_REARM  = 1'b1;

	// Element sizes (bytes minus one)
	localparam logic [1:0] SIZE_BYTE  = 2'd0;
	localparam logic [1:0] SIZE_HALF  = 2'd1;
	localparam logic [1:0] SIZE_TRIPLE = 2'd2;
	localparam logic [1:0] SIZE_WORD  = 2'd3;

	// Comparative tests; the remaining codes never match
	localparam logic [2:0] CMP_GT = 3'd0;
	localparam logic [2:0] CMP_LT = 3'd1;
	localparam logic [2:0] CMP_EQ = 3'd2;
	localparam logic [2:0] CMP_NE = 3'd3;

	typedef logic [VALUE_W-1:0] value_t;

	// Value mask for an element size
	function automatic value_t value_mask(input logic [1:0] size);
		value_t m;
		case (size)
			SIZE_BYTE:   m = 32'h0000_00FF;
			SIZE_HALF:   m = 32'h0000_FFFF;
			SIZE_TRIPLE: m = 32'h00FF_FFFF;
			default:     m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	// Candidate bits of an element, clipped to its first byte's map entry
	function automatic logic [7:0] byte_mask(input logic [1:0] size, input logic [2:0] offs);
		logic [3:0]  bm;
		logic [10:0] w;
		case (size)
			SIZE_BYTE:   bm = 4'h1;
			SIZE_HALF:   bm = 4'h3;
			SIZE_TRIPLE: bm = 4'h7;
			default:     bm = 4'hF;
		endcase
		w = 11'(bm) << offs;
		return w[7:0];
	endfunction

endpackage

FILE: sv/memory_search_candidate_filter_core.sv
// Top level of the memory search candidate filter: bitmap memory, filter pipeline
// and survivor counter. Depends on mscf_pkg.
//
// Takes one scanned element per cycle, back to back, while out_ready stays
// high and no clearing pass runs; each result passes through the stage 1
// registers and is held in an output register. The candidate bitmap sits in
// one single-port-write, registered-read memory of ceil(min(MEM_BYTES, 2^22)/8)
// bytes (at most 2^19 entries); a read-modify-write per item, with the last
// write forwarded when consecutive items hit the same entry, sets the one
// item per cycle figure. After reset a clearing pass writes all ones to every
// bitmap entry, one entry per cycle; in_ready stays low until it ends, while
// configuration writes are taken throughout.
module memory_search_candidate_filter_core
	import mscf_pkg::*;
#(
	parameter int unsigned MEM_BYTES = 4194304
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// item channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [ADDR_W-1:0]  elem_address,
	input  logic [VALUE_W-1:0] current_value,
	input  logic [VALUE_W-1:0] previous_value,
	input  logic               first_of_pass,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               was_candidate,
	output logic               still_candidate,
	output logic [COUNT_W-1:0] match_count
);

	localparam int unsigned ADDR_SPAN = (MEM_BYTES < (2**ADDR_W)) ? MEM_BYTES : (2**ADDR_W);
	localparam int unsigned MAP_DEPTH = (ADDR_SPAN + 7) / 8;
	localparam int unsigned IDX_W     = $clog2(MAP_DEPTH);

	// Configuration registers
	logic         search_mode_q;
	logic [1:0]   element_size_q;
	logic [2:0]   compare_op_q;
	value_t       target_value_q;

	// Control state
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             v_s1;
	logic [COUNT_W-1:0] cnt_q;

	// Stage 1 payload
	logic             cmd_s1;
	logic             first_s1;
	logic             inrange_s1;
	logic             pass_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [7:0]       mask_s1;
	logic [7:0]       map_rd_s1;
	logic             fwd_hit_s1;
	logic [7:0]       fwd_data_s1;

	// Bitmap memory
	logic [7:0]       map_mem [MAP_DEPTH];
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [7:0]       mem_wdata;

	// Combinational
	logic             in_accept;
	logic             s1_adv;
	logic             s1_we;
	logic             in_range;
	logic [IDX_W-1:0] in_idx;
	value_t           vmask;
	value_t           cur_m;
	value_t           prev_m;
	logic             cmp_hit;
	logic             pass;
	logic [7:0]       cur_map;
	logic             was;
	logic             still;
	logic [7:0]       new_map;
	logic             inc;
	logic [COUNT_W-1:0] cnt_base;
	logic [COUNT_W-1:0] cnt_next;

	assign cfg_ready = 1'b1;

	// Handshakes
	assign s1_adv    = v_s1 && (!out_valid || out_ready);
	assign in_ready  = !clr_busy_q && (!v_s1 || s1_adv);
	assign in_accept = in_valid && in_ready;

	// Stage 0: address decode and element test
	assign in_range = (32'(elem_address) < MEM_BYTES);
	assign in_idx   = elem_address[IDX_W+2:3];
	assign vmask    = value_mask(element_size_q);
	assign cur_m    = current_value & vmask;
	assign prev_m   = previous_value & vmask;

	always_comb begin
		case (compare_op_q)
			CMP_GT:  cmp_hit = (cur_m > prev_m);
			CMP_LT:  cmp_hit = (cur_m < prev_m);
			CMP_EQ:  cmp_hit = (cur_m == prev_m);
			CMP_NE:  cmp_hit = (cur_m != prev_m);
			default: cmp_hit = 1'b0;
		endcase
	end

	assign pass = (search_mode_q == MODE_EXACT) ? (cur_m == target_value_q) : cmp_hit;

	// Stage 1: modify the entry, count survivors
	assign cur_map = fwd_hit_s1 ? fwd_data_s1 : map_rd_s1;
	assign was     = inrange_s1 && ((cur_map & mask_s1) != 8'h00);

	always_comb begin
		if (cmd_s1 == CMD_REARM) begin
			new_map = cur_map | mask_s1;
		end else if (was && pass_s1) begin
			new_map = cur_map | mask_s1;
		end else if (was) begin
			new_map = cur_map & ~mask_s1;
		end else begin
			new_map = cur_map;
		end
	end

	assign still    = inrange_s1 && ((cmd_s1 == CMD_REARM) || (was && pass_s1));
	assign inc      = (cmd_s1 == CMD_FILTER) && was && pass_s1;
	assign cnt_base = first_s1 ? '0 : cnt_q;
	assign cnt_next = (inc && (cnt_base != COUNT_MAX)) ? (cnt_base + 1'b1) : cnt_base;
	assign s1_we    = s1_adv && inrange_s1;

	// Memory write port: clearing pass or stage 1 write-back
	assign mem_we    = clr_busy_q || s1_we;
	assign mem_waddr = clr_busy_q ? clr_idx_q : idx_s1;
	assign mem_wdata = clr_busy_q ? 8'hFF : new_map;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (in_accept) begin
			map_rd_s1 <= map_mem[in_idx];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_mode_q  <= MODE_EXACT;
			element_size_q <= SIZE_BYTE;
			compare_op_q   <= CMP_GT;
			target_value_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEARCH_MODE:  search_mode_q  <= cfg_data[0];
				REG_ELEMENT_SIZE: element_size_q <= cfg_data[1:0];
				REG_COMPARE_OP:   compare_op_q   <= cfg_data[2:0];
				REG_TARGET_VALUE: target_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control: clearing sweep, stage valid, counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			v_s1       <= 1'b0;
			cnt_q      <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == IDX_W'(MAP_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (in_accept) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				cnt_q     <= cnt_next;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1      <= command;
			first_s1    <= first_of_pass;
			inrange_s1  <= in_range;
			pass_s1     <= pass;
			idx_s1      <= in_idx;
			mask_s1     <= byte_mask(element_size_q, elem_address[2:0]);
			// same-entry write landing on the edge of this read
			fwd_hit_s1  <= s1_we && (idx_s1 == in_idx);
			fwd_data_s1 <= new_map;
		end
		if (s1_adv) begin
			was_candidate   <= was;
			still_candidate <= still;
			match_count     <= cnt_next;
		end
	end

	// Checks
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_ready)
		else $error("item taken during clearing pass");

	a_rearm_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && inrange_s1 && (cmd_s1 == CMD_REARM)) |=> (out_valid && still_candidate))
		else $error("re-arm did not leave a candidate");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !first_s1) |-> (cnt_next >= cnt_q))
		else $error("survivor count fell within a pass");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_adv) |-> !in_accept)
		else $error("item accepted over a stalled stage");

endmodule

FILE: tb/memory_search_candidate_filter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for memory_search_candidate_filter_core: a scoreboard class tracks
// the candidate bitmap and survivor count and checks every result transaction in order.
// Depends on mscf_pkg and the core.
module memory_search_candidate_filter_core_tb;
	import mscf_pkg::*;

	localparam int unsigned MEM_BYTES = 4194304;

	typedef struct packed {
		logic               cmd;
		logic [ADDR_W-1:0]  addr;
		value_t             cur;
		value_t             prev;
		logic               first;
	} element_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic               was;
		logic               still;
		logic [COUNT_W-1:0] count;
	} verdict_t;

	// Bitmap and counter tracker; predicts one verdict per accepted element
	class candidate_scoreboard;
		bit [7:0]           cand_map [int unsigned];
		logic [COUNT_W-1:0] survivors;
		logic               mode;
		logic [1:0]         size;
		logic [2:0]         op;
		value_t             target;
		verdict_t           pending_verdicts [$];
		int unsigned        errors;

		function new();
			survivors = '0;
			mode      = MODE_EXACT;
			size      = SIZE_BYTE;
			op        = CMP_GT;
			target    = '0;
			errors    = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				REG_SEARCH_MODE:  mode   = data[0];
				REG_ELEMENT_SIZE: size   = data[1:0];
				REG_COMPARE_OP:   op     = data[2:0];
				REG_TARGET_VALUE: target = data;
				default: ;
			endcase
		endfunction

		// Keep/drop test on the size-masked values
		function bit survives(value_t cur, value_t prev);
			value_t vmask;
			value_t c;
			value_t p;
			vmask = {VALUE_W{1'b1}} >> (8 * (3 - int'(size)));
			c = cur & vmask;
			p = prev & vmask;
			if (mode == MODE_EXACT)
				return c == target;
			case (op)
				CMP_GT:  return c > p;
				CMP_LT:  return c < p;
				CMP_EQ:  return c == p;
				CMP_NE:  return c != p;
				default: return 1'b0;
			endcase
		endfunction

		function void note_element(element_t e);
			verdict_t    v;
			logic [15:0] span;
			logic [7:0]  lanes;
			logic [7:0]  bits;
			int unsigned idx;
			v = '0;
			v.addr = e.addr;
			if (e.first)
				survivors = '0;
			if (e.addr < MEM_BYTES) begin
				idx = e.addr >> 3;
				// element lanes, clipped to the entry of its first byte
				span = ((16'd1 << (size + 3'd1)) - 16'd1) << e.addr[2:0];
				lanes = span[7:0];
				bits = cand_map.exists(idx) ? cand_map[idx] : 8'hFF;
				v.was = |(bits & lanes);
				if (e.cmd == CMD_REARM) begin
					bits = bits | lanes;
					v.still = 1'b1;
				end else if (v.was) begin
					if (survives(e.cur, e.prev)) begin
						bits = bits | lanes;
						if (survivors != COUNT_MAX)
							survivors++;
						v.still = 1'b1;
					end else begin
						bits = bits & ~lanes;
					end
				end
				cand_map[idx] = bits;
			end
			v.count = survivors;
			pending_verdicts.push_back(v);
		endfunction

		function void check_verdict(logic was, logic still, logic [COUNT_W-1:0] count);
			verdict_t exp_v;
			if (pending_verdicts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: was=%0b still=%0b count=%0d",
						was, still, count);
				return;
			end
			exp_v = pending_verdicts.pop_front();
			if (was !== exp_v.was || still !== exp_v.still || count !== exp_v.count) begin
				errors++;
				if (errors <= 10)
					$display("address 0x%06h: expected was=%0b still=%0b count=%0d, got %0b %0b %0d",
						exp_v.addr, exp_v.was, exp_v.still, exp_v.count, was, still, count);
			end
		endfunction

		function int unsigned outstanding();
			return pending_verdicts.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n         = 1'b0;
	logic               cfg_valid      = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index      = '0;
	logic [31:0]        cfg_data       = '0;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic               command        = CMD_FILTER;
	logic [ADDR_W-1:0]  elem_address   = '0;
	logic [VALUE_W-1:0] current_value  = '0;
	logic [VALUE_W-1:0] previous_value = '0;
	logic               first_of_pass  = 1'b0;
	logic               out_valid;
	logic               out_ready      = 1'b0;
	logic               was_candidate;
	logic               still_candidate;
	logic [COUNT_W-1:0] match_count;

	candidate_scoreboard sb = new();

	bit          idling       = 1'b1;
	int unsigned hold_request = 0;

	// stimulus copy of the settings
	logic        st_mode;
	logic [1:0]  st_size;
	logic [2:0]  st_op;
	value_t      st_target;

	memory_search_candidate_filter_core #(
		.MEM_BYTES(MEM_BYTES)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.elem_address   (elem_address),
		.current_value  (current_value),
		.previous_value (previous_value),
		.first_of_pass  (first_of_pass),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.was_candidate  (was_candidate),
		.still_candidate(still_candidate),
		.match_count    (match_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit: clearing pass plus a slow run, taken several times over
	initial begin
		#30_000_000;
		$display("memory_search_candidate_filter_core: mismatch");
		$finish;
	end

	// Result side: checks each transaction, stalls in bursts, long hold-off on request
	initial begin : result_sink
		int unsigned stall_left;
		int unsigned hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_verdict(was_candidate, still_candidate, match_count);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(1, 11) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// Wait for the block to go quiet, then write every register
	task automatic apply_settings(input logic mode, input logic [1:0] size,
			input logic [2:0] op, input value_t target);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_SEARCH_MODE, 32'(mode));
		write_reg(REG_ELEMENT_SIZE, 32'(size));
		write_reg(REG_COMPARE_OP, 32'(op));
		write_reg(REG_TARGET_VALUE, target);
		cfg_valid <= 1'b0;
		st_mode = mode;
		st_size = size;
		st_op = op;
		st_target = target;
	endtask

	// One element transaction, then perhaps an idle burst
	task automatic send_element(input element_t e);
		int unsigned gap;
		in_valid <= 1'b1;
		command <= e.cmd;
		elem_address <= e.addr;
		current_value <= e.cur;
		previous_value <= e.prev;
		first_of_pass <= e.first;
		do @(posedge clk); while (!in_ready);
		sb.note_element(e);
		if (idling && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic push_element(input logic cmd, input logic [ADDR_W-1:0] addr,
			input value_t cur, input value_t prev, input logic first);
		element_t e;
		e.cmd = cmd;
		e.addr = addr;
		e.cur = cur;
		e.prev = prev;
		e.first = first;
		send_element(e);
	endtask

	// Repeated scan passes over small windows, with re-arms and stray elements mixed in
	task automatic run_search_phase(input int unsigned n_items);
		element_t    e;
		value_t      vmask;
		int unsigned sent;
		int unsigned base;
		int unsigned span;
		int unsigned sweeps;
		int unsigned stride;
		int unsigned roll;
		vmask = {VALUE_W{1'b1}} >> (8 * (3 - int'(st_size)));
		stride = st_size + 1;
		sent = 0;
		while (sent < n_items) begin
			base = ($urandom_range(0, 3) == 0) ? 32'h3FFFC0 + $urandom_range(0, 63)
				: $urandom_range(0, 32'h3FFFFF);
			span = $urandom_range(4, 16);
			sweeps = $urandom_range(1, 3);
			for (int unsigned s = 0; s < sweeps; s++) begin
				for (int unsigned k = 0; k < span; k++) begin
					e.cmd = CMD_FILTER;
					e.addr = ADDR_W'(base + k * stride);
					e.first = (k == 0);
					e.prev = $urandom;
					roll = $urandom_range(0, 99);
					if (st_mode == MODE_EXACT) begin
						e.cur = $urandom_range(0, 1) ? (($urandom & ~vmask) | (st_target & vmask))
							: $urandom;
					end else begin
						case ($urandom_range(0, 3))
							0:       e.cur = ($urandom & ~vmask) | (e.prev & vmask);
							1:       e.cur = e.prev + 1;
							2:       e.cur = e.prev - 1;
							default: e.cur = $urandom;
						endcase
					end
					if (roll < 8) begin
						// stray element anywhere
						e.cmd = $urandom_range(0, 1);
						e.addr = ADDR_W'($urandom);
						e.cur = $urandom;
						e.first = $urandom_range(0, 1);
					end else if (roll < 16) begin
						e.cmd = CMD_REARM;
					end
					send_element(e);
					sent++;
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic       mode;
		logic [1:0] size;
		logic [2:0] op;
		value_t     vmask;
		value_t     target;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Word elements, top target: lane clipping at the entry edge and re-arm
		apply_settings(MODE_EXACT, SIZE_WORD, CMP_GT, 32'hFFFF_FFFF);
		push_element(CMD_FILTER, 22'h000000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		push_element(CMD_FILTER, 22'h000004, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
		push_element(CMD_FILTER, 22'h000005, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		push_element(CMD_REARM,  22'h000006, 32'h0000_0000, 32'h0000_0000, 1'b0);
		push_element(CMD_FILTER, 22'h000005, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		push_element(CMD_FILTER, 22'h3FFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		in_valid <= 1'b0;

		// Target wider than a byte can never match
		apply_settings(MODE_EXACT, SIZE_BYTE, CMP_GT, 32'h0000_0100);
		push_element(CMD_FILTER, 22'h000008, 32'h0000_0100, 32'h0000_0000, 1'b1);
		in_valid <= 1'b0;

		// Upper byte masked off for three-byte elements
		apply_settings(MODE_EXACT, SIZE_TRIPLE, CMP_GT, 32'h0000_0000);
		push_element(CMD_FILTER, 22'h000010, 32'hFF00_0000, 32'h0000_0000, 1'b1);
		in_valid <= 1'b0;

		// Every comparison, including the codes that never match
		for (int unsigned k = 0; k < 8; k++) begin
			apply_settings(MODE_COMPARATIVE, SIZE_HALF, 3'(k), 32'h0000_0000);
			push_element(CMD_FILTER, ADDR_W'(32'h100 + 8 * k), 32'h1234_5678,
				32'hABCD_5678, 1'b1);
			if (k < 4) begin
				push_element(CMD_FILTER, ADDR_W'(32'h102 + 8 * k), 32'hABCD_8001,
					32'h1234_8000, 1'b0);
				push_element(CMD_FILTER, ADDR_W'(32'h104 + 8 * k), 32'h0000_0000,
					32'hFFFF_FFFF, 1'b0);
			end
			in_valid <= 1'b0;
		end

		// Random settings; a long receiver hold-off in one phase, no idling at the end
		for (int unsigned ph = 0; ph < 16; ph++) begin
			mode = $urandom_range(0, 1);
			size = $urandom_range(0, 3);
			op = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 7);
			vmask = {VALUE_W{1'b1}} >> (8 * (3 - int'(size)));
			target = ($urandom_range(0, 5) == 0) ? $urandom : ($urandom & vmask);
			apply_settings(mode, size, op, target);
			idling = (ph < 13) && (ph % 4 != 3) && (ph != 5);
			if (ph == 5)
				hold_request = 300;
			run_search_phase(80);
		end

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("memory_search_candidate_filter_core: match");
		else
			$display("memory_search_candidate_filter_core: mismatch");
		$finish;
	end

endmodule

FILE: memory_search_candidate_filter_core.f
sv/mscf_pkg.sv
sv/memory_search_candidate_filter_core.sv
tb/memory_search_candidate_filter_core_tb.sv
